// ===== hdl/mandelbrot_escape_time_macros.svh =====
// Assertion macros for the Mandelbrot escape-time block.
// No dependencies; the asserting files pull this header in by name.
`ifndef MANDELBROT_ESCAPE_TIME_MACROS_SVH
`define MANDELBROT_ESCAPE_TIME_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on clk and masked while rst_n is low.
`define MBE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mandelbrot_escape_time assertion failed");
// Next-cycle implication, checked on clk and masked while rst_n is low.
`define MBE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mandelbrot_escape_time assertion failed");
`else
`define MBE_ASSERT_IMP(lbl, ante, cons)
`define MBE_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== hdl/mbe_pkg.sv =====
// Shared types, constants and helper functions for the Mandelbrot block.
// No dependencies; used by every module of the block.
package mbe_pkg;

  localparam int HALF_WIDTH_DEF  = 320;
  localparam int HALF_HEIGHT_DEF = 240;
  localparam int ITER_LIMIT_DEF  = 255;
  localparam int FRAC_BITS_DEF   = 26;

  localparam int OFS_RE_W  = 10;
  localparam int OFS_IM_W  = 9;
  localparam int VAL_W     = 32;
  localparam int STEP_W    = 31;
  localparam int PROD_W    = 64;
  localparam int ITER_W    = 8;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_CENTER_RE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_IM  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_STEP = 2'd2;

  localparam logic signed [VAL_W-1:0] CENTER_RE_RST  = 32'sd6710886;
  localparam logic signed [VAL_W-1:0] CENTER_IM_RST  = 32'sd0;
  localparam logic        [STEP_W-1:0] PIXEL_STEP_RST = 31'd536871;

  typedef struct packed {
    logic busy;
    logic done;
  } core_stat_t;

  // True when the value is representable as a 32-bit signed number.
  function automatic logic fits32(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] ext;
    ext = $signed({{(PROD_W-VAL_W){v[VAL_W-1]}}, v[VAL_W-1:0]});
    return ext == v;
  endfunction

  function automatic logic signed [VAL_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
    logic signed [VAL_W-1:0] res;
    if (fits32(v)) begin
      res = v[VAL_W-1:0];
    end else if (v[PROD_W-1]) begin
      res = $signed({1'b1, {(VAL_W-1){1'b0}}});
    end else begin
      res = $signed({1'b0, {(VAL_W-1){1'b1}}});
    end
    return res;
  endfunction

endpackage

// ===== hdl/mandelbrot_escape_time.sv =====
// Top level of the Mandelbrot escape-time pixel evaluator: view registers,
// screen coordinates and result ports. Depends on mbe_pkg and mbe_core.
//
// Usage: drive in_offset_re / in_offset_im with a pixel offset from the view
// center and raise start; the transfer happens at a clock edge where start is
// high and busy is low. busy then stays high until the result is out.
// The result appears on out_screen_x, out_screen_y and out_iter_count for
// exactly one cycle, marked by out_valid; the receiver must take it then.
// A pixel ends when the new z of an iteration leaves the 32-bit range, or
// when its magnitude passes 4; that test waits for the squares of the new z
// from the next pass through the one shared 32x32 multiplier (a*a, b*b, a*b,
// then an update step to form the new z). A point that never escapes runs
// until the iteration limit is reached; a new start is taken in the cycle
// out_valid is shown.
// The view registers are written through cfg_valid / cfg_index / cfg_data
// (cfg_ready is always high) and must only be written while busy is low.
// Synchronous reset on rst_n low loads the default view and idles the block.
module mandelbrot_escape_time #(
  parameter int HALF_WIDTH  = mbe_pkg::HALF_WIDTH_DEF,
  parameter int HALF_HEIGHT = mbe_pkg::HALF_HEIGHT_DEF,
  parameter int ITER_LIMIT  = mbe_pkg::ITER_LIMIT_DEF,
  parameter int FRAC_BITS   = mbe_pkg::FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  logic signed [mbe_pkg::OFS_RE_W-1:0]    in_offset_re,
  input  logic signed [mbe_pkg::OFS_IM_W-1:0]    in_offset_im,
  output logic                                   out_valid,
  output logic        [mbe_pkg::OFS_RE_W-1:0]    out_screen_x,
  output logic        [mbe_pkg::OFS_IM_W-1:0]    out_screen_y,
  output logic        [mbe_pkg::ITER_W-1:0]      out_iter_count,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic        [mbe_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic        [mbe_pkg::VAL_W-1:0]       cfg_data
);

  logic signed [mbe_pkg::VAL_W-1:0]    center_re_r, center_im_r;
  logic        [mbe_pkg::STEP_W-1:0]   pixel_step_r;
  logic        [mbe_pkg::OFS_RE_W-1:0] scr_x_r;
  logic        [mbe_pkg::OFS_IM_W-1:0] scr_y_r;
  mbe_pkg::core_stat_t                 stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_re_r  <= mbe_pkg::CENTER_RE_RST;
      center_im_r  <= mbe_pkg::CENTER_IM_RST;
      pixel_step_r <= mbe_pkg::PIXEL_STEP_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mbe_pkg::REG_CENTER_RE:  center_re_r  <= $signed(cfg_data);
        mbe_pkg::REG_CENTER_IM:  center_im_r  <= $signed(cfg_data);
        mbe_pkg::REG_PIXEL_STEP: pixel_step_r <= cfg_data[mbe_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Screen coordinates wrap to their field widths.
  always_ff @(posedge clk) begin
    if (start && !stat.busy) begin
      scr_x_r <= $unsigned(in_offset_re) + mbe_pkg::OFS_RE_W'(HALF_WIDTH);
      scr_y_r <= $unsigned(in_offset_im) + mbe_pkg::OFS_IM_W'(HALF_HEIGHT);
    end
  end

  mbe_core #(
    .ITER_LIMIT (ITER_LIMIT),
    .FRAC_BITS  (FRAC_BITS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .offset_re  (in_offset_re),
    .offset_im  (in_offset_im),
    .center_re  (center_re_r),
    .center_im  (center_im_r),
    .pixel_step (pixel_step_r),
    .stat       (stat),
    .iter_count (out_iter_count)
  );

  assign busy         = stat.busy;
  assign out_valid    = stat.done;
  assign out_screen_x = scr_x_r;
  assign out_screen_y = scr_y_r;

endmodule

// ===== hdl/mbe_mul.sv =====
// Shared signed 32x32 multiplier with a registered 64-bit product.
// Depends on mbe_pkg for widths.
module mbe_mul (
  input  logic                                clk,
  input  logic signed [mbe_pkg::VAL_W-1:0]    op_a,
  input  logic signed [mbe_pkg::VAL_W-1:0]    op_b,
  output logic signed [mbe_pkg::PROD_W-1:0]   prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

endmodule

// ===== hdl/mbe_core.sv =====
// Sequencer and datapath of the escape-time iteration around one shared multiplier.
// Depends on mbe_pkg, mbe_mul and the assertion macro header.
`include "mandelbrot_escape_time_macros.svh"

module mbe_core #(
  parameter int ITER_LIMIT = mbe_pkg::ITER_LIMIT_DEF,
  parameter int FRAC_BITS  = mbe_pkg::FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  input  logic signed [mbe_pkg::OFS_RE_W-1:0]   offset_re,
  input  logic signed [mbe_pkg::OFS_IM_W-1:0]   offset_im,
  input  logic signed [mbe_pkg::VAL_W-1:0]      center_re,
  input  logic signed [mbe_pkg::VAL_W-1:0]      center_im,
  input  logic        [mbe_pkg::STEP_W-1:0]     pixel_step,
  output mbe_pkg::core_stat_t                   stat,
  output logic        [mbe_pkg::ITER_W-1:0]     iter_count
);

  localparam int CW = $clog2(ITER_LIMIT + 2);
  localparam int VW = mbe_pkg::VAL_W;
  localparam int PW = mbe_pkg::PROD_W;
  localparam int IW = mbe_pkg::ITER_W;
  localparam logic [PW-1:0] MAG_LIM = 64'd1 << (2 * FRAC_BITS + 2);
  localparam logic [CW-1:0] CNT_LIM = CW'(ITER_LIMIT);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CRE  = 3'd1;
  localparam logic [2:0] S_CIM  = 3'd2;
  localparam logic [2:0] S_AA   = 3'd3;
  localparam logic [2:0] S_BB   = 3'd4;
  localparam logic [2:0] S_AB   = 3'd5;
  localparam logic [2:0] S_UPD  = 3'd6;

  logic [2:0]                       state_r, state_nxt;
  logic [CW-1:0]                    cnt_r, cnt_nxt, cnt_inc;
  logic                             chk_r, chk_nxt;
  logic                             done_r, done_nxt;
  logic [IW-1:0]                    iter_r, iter_nxt;
  logic signed [mbe_pkg::OFS_RE_W-1:0] ox_r;
  logic signed [mbe_pkg::OFS_IM_W-1:0] oy_r;
  logic signed [VW-1:0]             a_r, b_r, cre_r, cim_r;
  logic signed [PW-1:0]             aa_r, bb_r;
  logic signed [PW-1:0]             prod_r;
  logic signed [VW-1:0]             mul_a, mul_b;
  logic signed [VW-1:0]             center_sel;
  logic signed [PW-1:0]             c_sum;
  logic signed [VW-1:0]             c_sat;
  logic signed [PW-1:0]             a2, b2;
  logic        [PW-1:0]             mag;
  logic                             esc_mag, fits_new;
  logic        [CW+IW-1:0]          cnt_ext, inc_ext;

  mbe_mul u_mul (
    .clk    (clk),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .prod_r (prod_r)
  );

  always_comb begin
    case (state_r)
      S_CRE: begin
        mul_a = $signed({{(VW-mbe_pkg::OFS_RE_W){ox_r[mbe_pkg::OFS_RE_W-1]}}, ox_r});
        mul_b = $signed({1'b0, pixel_step});
      end
      S_CIM: begin
        mul_a = $signed({{(VW-mbe_pkg::OFS_IM_W){oy_r[mbe_pkg::OFS_IM_W-1]}}, oy_r});
        mul_b = $signed({1'b0, pixel_step});
      end
      S_BB: begin
        mul_a = b_r;
        mul_b = b_r;
      end
      S_AB: begin
        mul_a = a_r;
        mul_b = b_r;
      end
      default: begin
        mul_a = a_r;
        mul_b = a_r;
      end
    endcase
  end

  // The offset product is registered, so the one issued in S_CRE is read in S_CIM
  // to form the real part of c, and the one from S_CIM forms the imaginary part in the first S_AA.
  assign center_sel = (state_r == S_CIM) ? center_re : center_im;
  assign c_sum      = $signed({{(PW-VW){center_sel[VW-1]}}, center_sel}) + prod_r;
  assign c_sat      = mbe_pkg::sat32(c_sum);

  // In S_UPD the multiplier holds a*b; the squares were parked earlier.
  assign a2 = (aa_r >>> FRAC_BITS) - (bb_r >>> FRAC_BITS)
            + $signed({{(PW-VW){cre_r[VW-1]}}, cre_r});
  assign b2 = (prod_r >>> (FRAC_BITS - 1)) + $signed({{(PW-VW){cim_r[VW-1]}}, cim_r});
  assign fits_new = mbe_pkg::fits32(a2) && mbe_pkg::fits32(b2);

  // The squares of the new z are the next iteration's a*a and b*b, so the
  // magnitude test runs in S_AB once both are known.
  assign mag     = $unsigned(aa_r) + $unsigned(prod_r);
  assign esc_mag = chk_r && (mag > MAG_LIM);

  assign cnt_inc = cnt_r + 1'b1;
  assign cnt_ext = {{IW{1'b0}}, cnt_r};
  assign inc_ext = {{IW{1'b0}}, cnt_inc};

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    chk_nxt   = chk_r;
    done_nxt  = 1'b0;
    iter_nxt  = iter_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_CRE;
          cnt_nxt   = '0;
          chk_nxt   = 1'b0;
        end
      end
      S_CRE: state_nxt = S_CIM;
      S_CIM: state_nxt = S_AA;
      S_AA:  state_nxt = S_BB;
      S_BB:  state_nxt = S_AB;
      S_AB: begin
        if (esc_mag) begin
          state_nxt = S_IDLE;
          done_nxt  = 1'b1;
          iter_nxt  = cnt_ext[IW-1:0];
        end else begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        if (!fits_new || (cnt_inc > CNT_LIM)) begin
          state_nxt = S_IDLE;
          done_nxt  = 1'b1;
          iter_nxt  = (cnt_inc > CNT_LIM) ? '0 : inc_ext[IW-1:0];
        end else begin
          state_nxt = S_AA;
          cnt_nxt   = cnt_inc;
          chk_nxt   = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      chk_r   <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      chk_r   <= chk_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    iter_r <= iter_nxt;
    if ((state_r == S_IDLE) && start) begin
      ox_r <= offset_re;
      oy_r <= offset_im;
    end
    if (state_r == S_CIM) begin
      a_r   <= c_sat;
      cre_r <= c_sat;
    end
    if ((state_r == S_AA) && !chk_r) begin
      b_r   <= c_sat;
      cim_r <= c_sat;
    end
    if (state_r == S_BB) begin
      aa_r <= prod_r;
    end
    if (state_r == S_AB) begin
      bb_r <= prod_r;
    end
    if (state_r == S_UPD) begin
      a_r <= a2[VW-1:0];
      b_r <= b2[VW-1:0];
    end
  end

  assign stat.busy  = (state_r != S_IDLE);
  assign stat.done  = done_r;
  assign iter_count = iter_r;

  `MBE_ASSERT_NXT(a_start_launches, (state_r == S_IDLE) && start, state_r == S_CRE)
  `MBE_ASSERT_IMP(a_cnt_in_range, state_r != S_IDLE, cnt_r <= CNT_LIM)
  `MBE_ASSERT_IMP(a_first_pass_flag, state_r == S_UPD, chk_r == (cnt_r != '0))
  `MBE_ASSERT_NXT(a_done_single, done_r, !done_r && (state_r != S_UPD))

endmodule
